### hdl/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

    localparam int NUM_BUFFERS_DEF = 32;
    localparam int REF_BITS_DEF    = 8;

    localparam int CMD_W    = 3;
    localparam int DEV_W    = 32;
    localparam int BLK_W    = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 2;

    // input beat layout, lowest field first
    localparam int CMD_LSB   = 0;
    localparam int DEV_LSB   = CMD_LSB + CMD_W;
    localparam int BLK_LSB   = DEV_LSB + DEV_W;
    localparam int SLOT_LSB  = BLK_LSB + BLK_W;
    localparam int S_TDATA_W = ((SLOT_LSB + SLOT_W + 7) / 8) * 8;

    localparam int RES_W     = SLOT_W + 1 + 1 + STATUS_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET     = 3'd0,
        CMD_READ    = 3'd1,
        CMD_RELEASE = 3'd2,
        CMD_PIN     = 3'd3,
        CMD_UNPIN   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_FREE   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // packed so that slot_out sits in the lowest bits
    typedef struct packed {
        status_t             status;
        logic                fill_needed;
        logic                hit;
        logic [SLOT_W-1:0]   slot_out;
    } result_t;

endpackage

`default_nettype wire

### hdl/bbc_ram.sv
`default_nettype none

module bbc_ram #(
    parameter int DEPTH  = bbc_pkg::NUM_BUFFERS_DEF,
    parameter int DATA_W = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    output logic                   rd_written
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_written_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // one flag per entry marks whether it has been written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_written = rd_written_reg;

endmodule

`default_nettype wire

### hdl/block_buffer_cache_mru.sv
// Get and read: the recency list is walked front to back, one entry per cycle through the
//   list memory and then the entry memory; the walk stops at the first match, or at the
//   end of the list on a miss.
// Pin, unpin and release: the slot's entry is read and then updated; a release that drops
//   the count to zero also rotates the entry to the front of the list.
// One item is in work at a time; the next beat is taken as soon as the result sits in the
//   output register. Reset is synchronous: all entries read as zero and the list as 0..N-1.
`default_nettype none

module block_buffer_cache_mru #(
    parameter int NUM_BUFFERS = bbc_pkg::NUM_BUFFERS_DEF,
    parameter int REF_BITS    = bbc_pkg::REF_BITS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // cmd[2:0], dev[34:3], block_number[66:35], slot[71:67]
    input  wire logic [bbc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // slot_out[4:0], hit[5], fill_needed[6], status[8:7], zeros above
    output logic      [bbc_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W = $clog2(NUM_BUFFERS);
    localparam int POS_W = $clog2(NUM_BUFFERS + 1);
    localparam int DEV_W = bbc_pkg::DEV_W;
    localparam int BLK_W = bbc_pkg::BLK_W;
    localparam int ENT_W = DEV_W + BLK_W + REF_BITS + 1;
    localparam logic [REF_BITS-1:0] REF_MAX  = '1;
    localparam logic [POS_W-1:0]    POS_END  = POS_W'(NUM_BUFFERS);
    localparam logic [POS_W-1:0]    POS_LAST = POS_W'(NUM_BUFFERS - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_LOOK   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_ROTATE = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t                             state_reg, state_next;
    logic [bbc_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [DEV_W-1:0]                   dev_reg, dev_next;
    logic [BLK_W-1:0]                   blk_reg, blk_next;
    logic [bbc_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [POS_W-1:0]                   issue_pos_reg, issue_pos_next;
    logic                               a_vld_reg, a_vld_next;
    logic [IDX_W-1:0]                   a_pos_reg, a_pos_next;
    logic                               b_vld_reg, b_vld_next;
    logic [IDX_W-1:0]                   b_idx_reg, b_idx_next;
    logic [POS_W-1:0]                   cmp_pos_reg, cmp_pos_next;
    logic                               match_reg, match_next;
    logic [IDX_W-1:0]                   match_idx_reg, match_idx_next;
    logic [ENT_W-1:0]                   match_data_reg, match_data_next;
    logic                               free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]                   free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]                   carry_reg, carry_next;
    logic [IDX_W-1:0]                   wpos_reg, wpos_next;
    bbc_pkg::result_t                   res_reg, res_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [bbc_pkg::M_TDATA_W-1:0]      m_tdata_reg, m_tdata_next;

    logic                               order_rd_en, order_wr_en, order_written;
    logic [IDX_W-1:0]                   order_rd_addr, order_wr_addr, order_wr_data;
    logic [IDX_W-1:0]                   order_raw, order_rdata;
    logic                               entry_rd_en, entry_wr_en, entry_written;
    logic [IDX_W-1:0]                   entry_rd_addr, entry_wr_addr;
    logic [ENT_W-1:0]                   entry_wr_data, entry_raw, entry_rdata;

    logic [bbc_pkg::CMD_W-1:0]          in_cmd;
    logic [DEV_W-1:0]                   in_dev;
    logic [BLK_W-1:0]                   in_blk;
    logic [bbc_pkg::SLOT_W-1:0]         in_slot;

    logic [DEV_W-1:0]                   e_dev;
    logic [BLK_W-1:0]                   e_blk;
    logic [REF_BITS-1:0]                e_refs;
    logic [REF_BITS-1:0]                md_refs;
    logic                               md_valid;
    logic                               is_read;
    logic [IDX_W-1:0]                   slot_idx;

    assign in_cmd  = s_tdata[bbc_pkg::CMD_LSB  +: bbc_pkg::CMD_W];
    assign in_dev  = s_tdata[bbc_pkg::DEV_LSB  +: DEV_W];
    assign in_blk  = s_tdata[bbc_pkg::BLK_LSB  +: BLK_W];
    assign in_slot = s_tdata[bbc_pkg::SLOT_LSB +: bbc_pkg::SLOT_W];

    // an unwritten list position holds its own index, an unwritten entry is all zero
    assign order_rdata = order_written ? order_raw : a_pos_reg;
    assign entry_rdata = entry_written ? entry_raw : '0;

    assign e_dev    = entry_rdata[0 +: DEV_W];
    assign e_blk    = entry_rdata[DEV_W +: BLK_W];
    assign e_refs   = entry_rdata[DEV_W + BLK_W +: REF_BITS];
    assign md_refs  = match_data_reg[DEV_W + BLK_W +: REF_BITS];
    assign md_valid = match_data_reg[ENT_W-1];
    assign is_read  = (cmd_reg == bbc_pkg::CMD_READ);
    assign slot_idx = IDX_W'(slot_reg);

    bbc_ram #(
        .DEPTH  (NUM_BUFFERS),
        .DATA_W (IDX_W)
    ) u_order_ram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (order_wr_en),
        .wr_addr    (order_wr_addr),
        .wr_data    (order_wr_data),
        .rd_en      (order_rd_en),
        .rd_addr    (order_rd_addr),
        .rd_data    (order_raw),
        .rd_written (order_written)
    );

    bbc_ram #(
        .DEPTH  (NUM_BUFFERS),
        .DATA_W (ENT_W)
    ) u_entry_ram (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (entry_wr_en),
        .wr_addr    (entry_wr_addr),
        .wr_data    (entry_wr_data),
        .rd_en      (entry_rd_en),
        .rd_addr    (entry_rd_addr),
        .rd_data    (entry_raw),
        .rd_written (entry_written)
    );

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        slot_next       = slot_reg;
        issue_pos_next  = issue_pos_reg;
        a_vld_next      = a_vld_reg;
        a_pos_next      = a_pos_reg;
        b_vld_next      = b_vld_reg;
        b_idx_next      = b_idx_reg;
        cmp_pos_next    = cmp_pos_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_data_next = match_data_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        carry_next      = carry_reg;
        wpos_next       = wpos_reg;
        res_next        = res_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        order_rd_en   = 1'b0;
        order_rd_addr = '0;
        order_wr_en   = 1'b0;
        order_wr_addr = '0;
        order_wr_data = '0;
        entry_rd_en   = 1'b0;
        entry_rd_addr = '0;
        entry_wr_en   = 1'b0;
        entry_wr_addr = '0;
        entry_wr_data = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = in_cmd;
                    dev_next  = in_dev;
                    blk_next  = in_blk;
                    slot_next = in_slot;
                    priority if (in_cmd == bbc_pkg::CMD_GET || in_cmd == bbc_pkg::CMD_READ) begin
                        issue_pos_next = '0;
                        a_vld_next     = 1'b0;
                        b_vld_next     = 1'b0;
                        cmp_pos_next   = '0;
                        match_next     = 1'b0;
                        free_vld_next  = 1'b0;
                        state_next     = S_SCAN;
                    end else if (in_cmd == bbc_pkg::CMD_RELEASE || in_cmd == bbc_pkg::CMD_PIN
                                 || in_cmd == bbc_pkg::CMD_UNPIN) begin
                        entry_rd_en   = 1'b1;
                        entry_rd_addr = IDX_W'(in_slot);
                        state_next    = S_LOOK;
                    end else begin
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN: begin
                // list read, then entry read, then compare: one position per cycle
                if (issue_pos_reg != POS_END) begin
                    order_rd_en    = 1'b1;
                    order_rd_addr  = issue_pos_reg[IDX_W-1:0];
                    a_pos_next     = issue_pos_reg[IDX_W-1:0];
                    issue_pos_next = issue_pos_reg + POS_W'(1);
                    a_vld_next     = 1'b1;
                end else begin
                    a_vld_next = 1'b0;
                end
                b_vld_next = a_vld_reg;
                if (a_vld_reg) begin
                    entry_rd_en   = 1'b1;
                    entry_rd_addr = order_rdata;
                    b_idx_next    = order_rdata;
                end
                if (b_vld_reg) begin
                    cmp_pos_next = cmp_pos_reg + POS_W'(1);
                    if (e_dev == dev_reg && e_blk == blk_reg) begin
                        match_next      = 1'b1;
                        match_idx_next  = b_idx_reg;
                        match_data_next = entry_rdata;
                        state_next      = S_UPDATE;
                    end else begin
                        if (!free_vld_reg && e_refs == '0) begin
                            free_vld_next = 1'b1;
                            free_idx_next = b_idx_reg;
                        end
                        if (cmp_pos_reg == POS_LAST) begin
                            state_next = S_UPDATE;
                        end
                    end
                end
            end

            S_UPDATE: begin
                priority if (match_reg) begin
                    entry_wr_en   = 1'b1;
                    entry_wr_addr = match_idx_reg;
                    entry_wr_data = {md_valid | is_read,
                                     (md_refs == REF_MAX) ? REF_MAX
                                                          : md_refs + REF_BITS'(1),
                                     blk_reg, dev_reg};
                    res_next.status      = (md_refs == REF_MAX) ? bbc_pkg::ST_OVERFLOW
                                                                : bbc_pkg::ST_OK;
                    res_next.fill_needed = is_read & ~md_valid;
                    res_next.hit         = 1'b1;
                    res_next.slot_out    = bbc_pkg::SLOT_W'(match_idx_reg);
                end else if (free_vld_reg) begin
                    // claim: new tag, count one, invalid unless a read fills it
                    entry_wr_en   = 1'b1;
                    entry_wr_addr = free_idx_reg;
                    entry_wr_data = {is_read, REF_BITS'(1), blk_reg, dev_reg};
                    res_next.status      = bbc_pkg::ST_OK;
                    res_next.fill_needed = is_read;
                    res_next.hit         = 1'b0;
                    res_next.slot_out    = bbc_pkg::SLOT_W'(free_idx_reg);
                end else begin
                    res_next        = '0;
                    res_next.status = bbc_pkg::ST_NO_FREE;
                end
                state_next = S_FINISH;
            end

            S_LOOK: begin
                res_next          = '0;
                res_next.slot_out = slot_reg;
                state_next        = S_FINISH;
                if (int'(slot_reg) < NUM_BUFFERS) begin
                    if (cmd_reg == bbc_pkg::CMD_PIN) begin
                        entry_wr_en   = 1'b1;
                        entry_wr_addr = slot_idx;
                        entry_wr_data = entry_rdata;
                        if (e_refs == REF_MAX) begin
                            res_next.status = bbc_pkg::ST_OVERFLOW;
                        end else begin
                            entry_wr_data[DEV_W + BLK_W +: REF_BITS] = e_refs + REF_BITS'(1);
                        end
                    end else if (e_refs == '0) begin
                        res_next.status = bbc_pkg::ST_UNDERFLOW;
                    end else begin
                        entry_wr_en   = 1'b1;
                        entry_wr_addr = slot_idx;
                        entry_wr_data = entry_rdata;
                        entry_wr_data[DEV_W + BLK_W +: REF_BITS] = e_refs - REF_BITS'(1);
                        if (cmd_reg == bbc_pkg::CMD_RELEASE && e_refs == REF_BITS'(1)) begin
                            issue_pos_next = '0;
                            a_vld_next     = 1'b0;
                            carry_next     = slot_idx;
                            wpos_next      = '0;
                            state_next     = S_ROTATE;
                        end
                    end
                end
            end

            S_ROTATE: begin
                // shift the list down by one from the front until the released entry is met
                if (issue_pos_reg != POS_END) begin
                    order_rd_en    = 1'b1;
                    order_rd_addr  = issue_pos_reg[IDX_W-1:0];
                    a_pos_next     = issue_pos_reg[IDX_W-1:0];
                    issue_pos_next = issue_pos_reg + POS_W'(1);
                    a_vld_next     = 1'b1;
                end else begin
                    a_vld_next = 1'b0;
                end
                if (a_vld_reg) begin
                    order_wr_en   = 1'b1;
                    order_wr_addr = wpos_reg;
                    order_wr_data = carry_reg;
                    carry_next    = order_rdata;
                    wpos_next     = wpos_reg + IDX_W'(1);
                    if (order_rdata == slot_idx) begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = bbc_pkg::M_TDATA_W'(res_reg);
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            a_vld_reg    <= a_vld_next;
            b_vld_reg    <= b_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        dev_reg        <= dev_next;
        blk_reg        <= blk_next;
        slot_reg       <= slot_next;
        issue_pos_reg  <= issue_pos_next;
        a_pos_reg      <= a_pos_next;
        b_idx_reg      <= b_idx_next;
        cmp_pos_reg    <= cmp_pos_next;
        match_reg      <= match_next;
        match_idx_reg  <= match_idx_next;
        match_data_reg <= match_data_next;
        free_vld_reg   <= free_vld_next;
        free_idx_reg   <= free_idx_next;
        carry_reg      <= carry_next;
        wpos_reg       <= wpos_next;
        res_reg        <= res_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### hdl/bbc_checker.sv
`default_nettype none

module bbc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [bbc_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bbc_pkg::M_TDATA_W-1:0] m_tdata
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one item at a time: the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // a fresh result never follows an accept in the very next cycle
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result appeared too early");

    // no free buffer leaves every other result field clear
    a_no_free_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8:7] == bbc_pkg::ST_NO_FREE |->
            m_tdata[6:0] == 7'd0)
        else $error("no-free result carries data");

    // a hit only goes with ok or overflow
    a_hit_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |->
            (m_tdata[8:7] == bbc_pkg::ST_OK || m_tdata[8:7] == bbc_pkg::ST_OVERFLOW))
        else $error("hit with impossible status");

endmodule

bind block_buffer_cache_mru bbc_checker u_bbc_checker (.*);

`default_nettype wire

### sim/buffer_cache_checker.sv
`default_nettype none

module buffer_cache_checker
    import bbc_pkg::*;
#(
    parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
    parameter int REF_BITS    = REF_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // cmd, dev, block_number, slot
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // slot_out, hit, fill_needed, status, zeros above
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REF_BITS-1:0] REF_MAX = '1;

    logic [DEV_W-1:0]    tag_dev  [NUM_BUFFERS];
    logic [BLK_W-1:0]    tag_blk  [NUM_BUFFERS];
    logic [REF_BITS-1:0] ref_cnt  [NUM_BUFFERS];
    logic                filled   [NUM_BUFFERS];
    int                  mru_list [NUM_BUFFERS];
    result_t             cache_replies_q[$];

    function automatic void clear_table();
        int i;
        for (i = 0; i < NUM_BUFFERS; i++) begin
            tag_dev[i]  = '0;
            tag_blk[i]  = '0;
            ref_cnt[i]  = '0;
            filled[i]   = 1'b0;
            mru_list[i] = i;
        end
    endfunction

    function automatic void bump_to_front(input int idx);
        int pos, i;
        pos = 0;
        for (i = NUM_BUFFERS - 1; i >= 0; i--)
            if (mru_list[i] == idx) pos = i;
        for (i = pos; i > 0; i--)
            mru_list[i] = mru_list[i-1];
        mru_list[0] = idx;
    endfunction

    function automatic result_t predict_cache_op(input logic [S_TDATA_W-1:0] beat);
        logic [CMD_W-1:0]  cmd;
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] slot;
        result_t           r;
        int                pos, e, found, free_e;
        bit                matched, have_free;
        cmd  = beat[CMD_LSB +: CMD_W];
        dev  = beat[DEV_LSB +: DEV_W];
        blk  = beat[BLK_LSB +: BLK_W];
        slot = beat[SLOT_LSB +: SLOT_W];
        r = '0;
        case (cmd)
            CMD_GET, CMD_READ: begin
                matched   = 1'b0;
                have_free = 1'b0;
                found     = 0;
                free_e    = 0;
                // walk front to back; remember the first unreferenced entry on the way
                for (pos = 0; pos < NUM_BUFFERS && !matched; pos++) begin
                    e = mru_list[pos];
                    if (tag_dev[e] == dev && tag_blk[e] == blk) begin
                        found   = e;
                        matched = 1'b1;
                    end else if (!have_free && ref_cnt[e] == '0) begin
                        free_e    = e;
                        have_free = 1'b1;
                    end
                end
                if (matched) begin
                    r.hit = 1'b1;
                    if (ref_cnt[found] == REF_MAX)
                        r.status = ST_OVERFLOW;
                    else
                        ref_cnt[found]++;
                end else if (have_free) begin
                    found          = free_e;
                    tag_dev[found] = dev;
                    tag_blk[found] = blk;
                    filled[found]  = 1'b0;
                    ref_cnt[found] = 1;
                end else begin
                    r.status = ST_NO_FREE;
                    return r;
                end
                if (cmd == CMD_READ) begin
                    r.fill_needed = !filled[found];
                    filled[found] = 1'b1;
                end
                r.slot_out = SLOT_W'(found);
            end
            CMD_RELEASE, CMD_PIN, CMD_UNPIN: begin
                r.slot_out = slot;
                if (slot < NUM_BUFFERS) begin
                    if (cmd == CMD_PIN) begin
                        if (ref_cnt[slot] == REF_MAX)
                            r.status = ST_OVERFLOW;
                        else
                            ref_cnt[slot]++;
                    end else if (ref_cnt[slot] == '0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        ref_cnt[slot]--;
                        if (cmd == CMD_RELEASE && ref_cnt[slot] == '0)
                            bump_to_front(slot);
                    end
                end
            end
            default: begin
                r = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want, got;
        int      pushed, popped;
        if (!aresetn) begin
            clear_table();
            cache_replies_q.delete();
            pending <= 0;
        end else begin
            pushed = 0;
            popped = 0;
            // pop before push: a result beat never belongs to the request taken at the same edge
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (cache_replies_q.size() == 0) begin
                    $error("result beat with nothing outstanding: tdata %h", m_tdata);
                    fail_count++;
                end else begin
                    want   = cache_replies_q.pop_front();
                    popped = 1;
                    check_field("slot_out", want.slot_out, got.slot_out);
                    check_field("hit", want.hit, got.hit);
                    check_field("fill_needed", want.fill_needed, got.fill_needed);
                    check_field("status", int'(want.status), int'(got.status));
                    check_field("tdata padding", 0, int'(m_tdata >> RES_W));
                end
            end
            if (s_tvalid && s_tready) begin
                cache_replies_q.push_back(predict_cache_op(s_tdata));
                pushed = 1;
            end
            pending <= pending + pushed - popped;
        end
    end

endmodule

`default_nettype wire

### sim/block_buffer_cache_mru_test.sv
`default_nettype none

module block_buffer_cache_mru_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bbc_pkg::*;

    localparam int NB             = NUM_BUFFERS_DEF;
    localparam int REF_TOP        = 2**REF_BITS_DEF - 1;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 64;
    localparam int POOL_SIZE      = 12;
    localparam int SLOT_TOP       = 2**SLOT_W - 1;
    localparam int CMD_TOP        = 2**CMD_W - 1;
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_UNPIN + 1);

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int                fail_count;
    int                pending;
    int                gap_pct      = 32;
    int                rx_idle_pct  = 32;
    int                beats_sent   = 0;
    int                quiet_cycles = 0;
    logic [SLOT_W-1:0] last_slot    = '0;
    status_t           last_status  = ST_OK;
    logic [DEV_W-1:0]  pool_dev [POOL_SIZE];
    logic [BLK_W-1:0]  pool_blk [POOL_SIZE];

    block_buffer_cache_mru uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    buffer_cache_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // keep the last reply so a sequence can act on the entry it was given
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            last_slot   <= m_tdata[SLOT_W-1:0];
            last_status <= status_t'(m_tdata[RES_W-1 -: STATUS_W]);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DEV_W-1:0] dev,
                             input logic [BLK_W-1:0] blk, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({slot, blk, dev, cmd});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic request_tag(input logic [CMD_W-1:0] cmd, input logic [DEV_W-1:0] dev,
                               input logic [BLK_W-1:0] blk);
        send_beat(cmd, dev, blk, SLOT_W'($urandom));
    endtask

    task automatic act_on_slot(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
        send_beat(cmd, $urandom, $urandom, slot);
    endtask

    // hold off the sender until every reply is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic run_working_set();
        int n, k, pick, p;
        n = $urandom_range(24, 8);
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99, 0);
            p    = $urandom_range(POOL_SIZE - 1, 0);
            if (pick < 30)
                request_tag(pick[0] ? CMD_READ : CMD_GET, pool_dev[p], pool_blk[p]);
            else if (pick < 36)
                request_tag(pick[0] ? CMD_READ : CMD_GET, $urandom, $urandom);
            else if (pick < 80)
                act_on_slot(CMD_RELEASE, SLOT_W'($urandom_range(SLOT_TOP, 0)));
            else if (pick < 87)
                act_on_slot(CMD_PIN, SLOT_W'($urandom_range(SLOT_TOP, 0)));
            else if (pick < 95)
                act_on_slot(CMD_UNPIN, SLOT_W'($urandom_range(SLOT_TOP, 0)));
            else
                send_beat(CMD_W'($urandom_range(CMD_TOP, CMD_FIRST_UNUSED)), $urandom,
                          $urandom, SLOT_W'($urandom));
        end
    endtask

    // claim past the table size, then drop every entry twice
    task automatic run_fill_up();
        int k;
        for (k = 0; k < NB + 2; k++)
            request_tag(k[0] ? CMD_READ : CMD_GET, $urandom, $urandom);
        for (k = 0; k < 2 * NB; k++)
            act_on_slot(CMD_RELEASE, SLOT_W'(k % NB));
    endtask

    task automatic run_release_pair();
        int p;
        p = $urandom_range(POOL_SIZE - 1, 0);
        request_tag(CMD_READ, pool_dev[p], pool_blk[p]);
        drain_results();
        if (last_status == ST_OK) begin
            act_on_slot(CMD_RELEASE, last_slot);
            request_tag(CMD_READ, pool_dev[p], pool_blk[p]);
        end
    endtask

    // drive one entry's count to its top and back past zero
    task automatic run_saturate();
        logic [DEV_W-1:0]  dev;
        logic [BLK_W-1:0]  blk;
        logic [SLOT_W-1:0] s;
        dev = $urandom;
        blk = $urandom;
        request_tag(CMD_GET, dev, blk);
        drain_results();
        if (last_status == ST_OK) begin
            s = last_slot;
            repeat (REF_TOP + 3) request_tag(CMD_GET, dev, blk);
            request_tag(CMD_READ, dev, blk);
            repeat (2) act_on_slot(CMD_PIN, s);
            repeat (REF_TOP + 3) act_on_slot(CMD_RELEASE, s);
            act_on_slot(CMD_UNPIN, s);
        end
    endtask

    initial begin
        int k, kind, first_random, c;
        for (k = 0; k < POOL_SIZE; k++) begin
            pool_dev[k] = (k < 8) ? DEV_W'($urandom) : pool_dev[4];
            pool_blk[k] = $urandom;
        end
        pool_dev[0] = '0;
        pool_blk[0] = '0;
        pool_dev[1] = '1;
        pool_blk[1] = '1;
        pool_dev[2] = '0;
        pool_blk[2] = '1;
        pool_dev[3] = '1;
        pool_blk[3] = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // untouched entries carry tag zero, so this hits entry 0
        request_tag(CMD_GET, '0, '0);
        request_tag(CMD_READ, '0, '0);
        request_tag(CMD_READ, '0, '0);
        request_tag(CMD_GET, '1, '1);
        request_tag(CMD_READ, '1, '0);
        request_tag(CMD_READ, '0, '1);
        request_tag(CMD_GET, 32'hAAAA_AAAA, 32'h5555_5555);
        repeat (3) act_on_slot(CMD_RELEASE, '0);
        act_on_slot(CMD_RELEASE, '0);
        act_on_slot(CMD_UNPIN, '1);
        act_on_slot(CMD_RELEASE, '1);
        act_on_slot(CMD_PIN, '1);
        act_on_slot(CMD_UNPIN, '1);
        for (c = CMD_FIRST_UNUSED; c <= CMD_TOP; c++)
            send_beat(CMD_W'(c), '1, '1, '1);
        send_beat(CMD_FIRST_UNUSED, '0, '0, '0);
        request_tag(CMD_GET, '0, '0);
        drain_results();

        first_random = beats_sent;
        run_saturate();
        while (beats_sent - first_random < RANDOM_ITEMS) begin
            if (beats_sent - first_random >= 800 && beats_sent - first_random < 1100) begin
                gap_pct     = 0;
                rx_idle_pct <= 0;
            end else begin
                gap_pct     = 32;
                rx_idle_pct <= 32;
            end
            kind = $urandom_range(99, 0);
            if (kind < 60)
                run_working_set();
            else if (kind < 75)
                run_fill_up();
            else if (kind < 98)
                run_release_pair();
            else
                run_saturate();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
